>>> sv/csv_field_tokenizer_core_defines.svh
// ---------------------------------------------------------------------------
// CSV field tokenizer: assertion macros
// Shared property macros for the tokenizer's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef CSV_FIELD_TOKENIZER_CORE_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CSVT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csvt: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CSVT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csvt: next-cycle check failed");

`endif

>>> sv/csvt_pkg.sv
// ---------------------------------------------------------------------------
// CSV field tokenizer package
// Shared types and constants for the tokenizer modules.
// ---------------------------------------------------------------------------
package csvt_pkg;

  localparam logic [7:0] BYTE_CR        = 8'd13;
  localparam logic [7:0] BYTE_LF        = 8'd10;
  localparam logic [7:0] DELIM_RST      = 8'd44;
  localparam logic [7:0] QUOTE_RST      = 8'd34;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DELIM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_QUOTE = 1'b1;

  typedef struct packed {
    logic [7:0] delim;
    logic [7:0] quote;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       content_valid;
    logic       field_end;
    logic       line_end;
    logic       row_error;
  } result_t;

  // Handshake between the input stage and the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } stage_t;

endpackage

>>> sv/csvt_if.sv
// ---------------------------------------------------------------------------
// CSV field tokenizer channels
// Valid/ready channels for the byte input and the token output.
// ---------------------------------------------------------------------------
interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface csvt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       content_valid;
  logic       field_end;
  logic       line_end;
  logic       row_error;

  modport source (output valid, output out_byte, output content_valid,
                  output field_end, output line_end, output row_error,
                  input ready);
  modport sink   (input valid, input out_byte, input content_valid,
                  input field_end, input line_end, input row_error,
                  output ready);
endinterface

>>> sv/csv_field_tokenizer_core.sv
// ---------------------------------------------------------------------------
// CSV field tokenizer core
// Splits a byte stream into CSV field and row tokens.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one text byte per transfer (valid/ready). out_ch carries
//   one token per transfer: a content byte, a field end, a row end, or a
//   row error flag. Delimiter and quote bytes are set over the cfg_ port
//   (index 0 delimiter, index 1 quote) while the block is idle.
//   The input register loads on the edge that transfers a byte in, and the
//   result register loads from it when it is empty or being drained.
//   Throughput is one byte per cycle while out_ch does not stall; quote
//   openings, closing quotes, the first quote of a doubled pair, skipped
//   bytes and the LF of a CRLF pair produce no token.
//   The per-byte field state machine sits between the two registers.
//   When out_ch stalls, the result register holds its token and the input
//   register takes one more byte; in_ch.ready then drops until the token
//   is taken.
//   Reset (rst_n low, synchronous) empties both registers, returns to the
//   start-of-field state and restores comma and double quote.
// ---------------------------------------------------------------------------
`include "csv_field_tokenizer_core_defines.svh"

module csv_field_tokenizer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  csvt_in_if.sink                        in_ch,
  csvt_out_if.source                     out_ch,
  input  logic                           cfg_wr_en,
  input  logic [csvt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_wr_data
);

  csvt_pkg::cfg_t    cfg;
  csvt_pkg::stage_t  stage;
  csvt_pkg::result_t res;
  logic              advance;
  logic              res_valid;

  csvt_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_wr_data),
    .cfg      (cfg)
  );

  csvt_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_data  (in_ch.in_byte),
    .in_ready (in_ch.ready),
    .advance  (advance),
    .stage    (stage)
  );

  csvt_parser u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .stage     (stage),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (out_ch.ready)
  );

  assign out_ch.valid         = res_valid;
  assign out_ch.out_byte      = res.out_byte;
  assign out_ch.content_valid = res.content_valid;
  assign out_ch.field_end     = res.field_end;
  assign out_ch.line_end      = res.line_end;
  assign out_ch.row_error     = res.row_error;

  logic out_data;
  logic out_mark;
  logic tok_marks;
  logic clean_eol;
  logic out_stall;

  assign out_data  = out_ch.valid && out_ch.content_valid;
  assign out_mark  = out_ch.valid && !out_ch.content_valid;
  assign tok_marks = out_ch.field_end || out_ch.line_end || out_ch.row_error;
  assign clean_eol = out_ch.valid && out_ch.line_end && !out_ch.row_error;
  assign out_stall = out_ch.valid && !out_ch.ready;

  // A content token carries no end or error marks; other tokens carry no byte.
  `CSVT_ASSERT_IMP(a_content_excl, clk, rst_n, out_data, !tok_marks)
  `CSVT_ASSERT_IMP(a_byte_zero, clk, rst_n, out_mark, out_ch.out_byte == 8'd0)
  // A clean row end always closes its last field.
  `CSVT_ASSERT_IMP(a_row_closes_field, clk, rst_n, clean_eol, out_ch.field_end)
  // Both registers full and output stalled: input must back-pressure.
  `CSVT_ASSERT_IMP(a_backpressure, clk, rst_n, stage.valid && out_stall, !in_ch.ready)

endmodule

>>> sv/csvt_cfg_regs.sv
// ---------------------------------------------------------------------------
// CSV field tokenizer configuration registers
// Delimiter and quote byte registers behind a plain write port.
// ---------------------------------------------------------------------------
module csvt_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [csvt_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [7:0]                     wr_data,
  output csvt_pkg::cfg_t                 cfg
);

  csvt_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delim <= csvt_pkg::DELIM_RST;
      cfg_r.quote <= csvt_pkg::QUOTE_RST;
    end else if (wr_en) begin
      case (wr_index)
        csvt_pkg::CFG_IDX_DELIM: cfg_r.delim <= wr_data;
        csvt_pkg::CFG_IDX_QUOTE: cfg_r.quote <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/csvt_in_stage.sv
// ---------------------------------------------------------------------------
// CSV field tokenizer input stage
// Registers one accepted byte ahead of the parser.
// ---------------------------------------------------------------------------
module csvt_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_data,
  output logic            in_ready,
  input  logic            advance,
  output csvt_pkg::stage_t stage
);

  logic       valid_r;
  logic [7:0] data_r;

  assign in_ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign stage.valid = valid_r;
  assign stage.data  = data_r;

endmodule

>>> sv/csvt_parser.sv
// ---------------------------------------------------------------------------
// CSV field tokenizer parser
// Field state machine and result register; one byte per cycle unless the result register stalls.
// ---------------------------------------------------------------------------
module csvt_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  csvt_pkg::cfg_t   cfg,
  input  csvt_pkg::stage_t stage,
  output logic             advance,
  output logic             res_valid,
  output csvt_pkg::result_t res,
  input  logic             res_ready
);

  typedef enum logic [2:0] {
    MODE_BEFORE = 3'd0,
    MODE_PLAIN  = 3'd1,
    MODE_QUOTED = 3'd2,
    MODE_QSEEN  = 3'd3,
    MODE_SKIP   = 3'd4
  } mode_t;

  mode_t             mode_r, mode_nxt;
  logic              cr_r, cr_nxt;
  logic              out_valid_r, hit_nxt;
  csvt_pkg::result_t out_r, out_nxt;

  logic [7:0] b;
  logic       is_delim, is_quote, is_eol, is_cr;

  assign b        = stage.data;
  assign is_delim = (b == cfg.delim);
  assign is_quote = (b == cfg.quote);
  assign is_cr    = (b == csvt_pkg::BYTE_CR);
  assign is_eol   = is_cr || (b == csvt_pkg::BYTE_LF);

  // Result register frees up when empty or being drained.
  assign advance = !out_valid_r || res_ready;

  always_comb begin
    mode_nxt = mode_r;
    cr_nxt   = 1'b0;
    hit_nxt  = 1'b0;
    out_nxt  = '0;
    if (cr_r && (b == csvt_pkg::BYTE_LF)) begin
      // swallow LF of a CRLF pair
      hit_nxt = 1'b0;
    end else begin
      case (mode_r)
        MODE_PLAIN: begin
          hit_nxt = 1'b1;
          if (is_delim) begin
            mode_nxt          = MODE_BEFORE;
            out_nxt.field_end = 1'b1;
          end else if (is_eol) begin
            mode_nxt          = MODE_BEFORE;
            cr_nxt            = is_cr;
            out_nxt.field_end = 1'b1;
            out_nxt.line_end  = 1'b1;
          end else begin
            out_nxt.out_byte      = b;
            out_nxt.content_valid = 1'b1;
          end
        end
        MODE_QUOTED: begin
          if (is_quote) begin
            mode_nxt = MODE_QSEEN;
          end else if (is_eol) begin
            hit_nxt           = 1'b1;
            mode_nxt          = MODE_BEFORE;
            cr_nxt            = is_cr;
            out_nxt.line_end  = 1'b1;
            out_nxt.row_error = 1'b1;
          end else begin
            hit_nxt               = 1'b1;
            out_nxt.out_byte      = b;
            out_nxt.content_valid = 1'b1;
          end
        end
        MODE_QSEEN: begin
          hit_nxt = 1'b1;
          if (is_delim) begin
            mode_nxt          = MODE_BEFORE;
            out_nxt.field_end = 1'b1;
          end else if (is_quote) begin
            mode_nxt              = MODE_QUOTED;
            out_nxt.out_byte      = cfg.quote;
            out_nxt.content_valid = 1'b1;
          end else if (is_eol) begin
            mode_nxt          = MODE_BEFORE;
            cr_nxt            = is_cr;
            out_nxt.field_end = 1'b1;
            out_nxt.line_end  = 1'b1;
          end else begin
            // stray byte after closing quote
            mode_nxt          = MODE_SKIP;
            out_nxt.row_error = 1'b1;
          end
        end
        MODE_SKIP: begin
          if (is_eol) begin
            hit_nxt           = 1'b1;
            mode_nxt          = MODE_BEFORE;
            cr_nxt            = is_cr;
            out_nxt.line_end  = 1'b1;
            out_nxt.row_error = 1'b1;
          end
        end
        default: begin
          if (is_delim) begin
            hit_nxt           = 1'b1;
            mode_nxt          = MODE_BEFORE;
            out_nxt.field_end = 1'b1;
          end else if (is_quote) begin
            mode_nxt = MODE_QUOTED;
          end else if (is_eol) begin
            hit_nxt           = 1'b1;
            mode_nxt          = MODE_BEFORE;
            cr_nxt            = is_cr;
            out_nxt.field_end = 1'b1;
            out_nxt.line_end  = 1'b1;
          end else begin
            hit_nxt               = 1'b1;
            mode_nxt              = MODE_PLAIN;
            out_nxt.out_byte      = b;
            out_nxt.content_valid = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_BEFORE;
      cr_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= stage.valid && hit_nxt;
      if (stage.valid) begin
        mode_r <= mode_nxt;
        cr_r   <= cr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage.valid) begin
      out_r <= out_nxt;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

>>> test/tb.sv
// ---------------------------------------------------------------------------
// CSV field tokenizer core testbench
// Streams directed and random CSV text through the tokenizer under several
// delimiter/quote settings with random input gaps and output stalls, and
// checks every token against a cycle-free model of the field state machine.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PM_BEFORE = 3'd0,
    PM_PLAIN  = 3'd1,
    PM_QUOTED = 3'd2,
    PM_QSEEN  = 3'd3,
    PM_SKIP   = 3'd4
  } parse_mode_t;

  localparam int ITEMS_PER_PHASE = 155;
  localparam int NUM_PHASES      = 9;
  localparam int LONG_HOLD       = 300;
  localparam int SETTLE_CYCLES   = 6;
  localparam int MAX_PRINTED     = 30;

  localparam logic [7:0] CH_CR    = csvt_pkg::BYTE_CR;
  localparam logic [7:0] CH_LF    = csvt_pkg::BYTE_LF;
  localparam logic [7:0] CH_DELIM = csvt_pkg::DELIM_RST;
  localparam logic [7:0] CH_QUOTE = csvt_pkg::QUOTE_RST;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_wr_en;
  logic [csvt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                     cfg_wr_data;

  csvt_in_if  in_ch ();
  csvt_out_if out_ch ();

  csv_field_tokenizer_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  always #2 clk = ~clk;

  // Model state and register copies
  logic [7:0]  delim_q;
  logic [7:0]  quote_q;
  parse_mode_t pmode;
  bit          after_cr;

  logic [7:0]        text_q[$];
  csvt_pkg::result_t pending_tokens[$];

  bit [31:0] mismatch_count = 0;
  bit [31:0] token_idx = 0;
  bit        in_fire = 1'b0;
  int        burst_left = 8;
  int        gap_left = 0;
  int        hold_req = 0;
  int        hold_ack = 0;
  int        hold_left = 0;
  int        stall_phase = 0;
  logic [15:0] stall_pat;

  // Next token for one text byte; returns 0 when the byte makes no token.
  function automatic bit tokenize_byte(input logic [7:0] b,
                                       output csvt_pkg::result_t tok);
    bit is_delim;
    bit is_quote;
    bit is_eol;
    is_delim = (b == delim_q);
    is_quote = (b == quote_q);
    is_eol   = (b == CH_CR) || (b == CH_LF);
    tok = '0;
    if (after_cr && b == CH_LF) begin
      after_cr = 1'b0;
      return 1'b0;
    end
    after_cr = 1'b0;
    case (pmode)
      PM_PLAIN: begin
        if (is_delim) begin
          pmode = PM_BEFORE;
          tok.field_end = 1'b1;
        end else if (is_eol) begin
          pmode = PM_BEFORE;
          after_cr = (b == CH_CR);
          tok.field_end = 1'b1;
          tok.line_end = 1'b1;
        end else begin
          tok.out_byte = b;
          tok.content_valid = 1'b1;
        end
        return 1'b1;
      end
      PM_QUOTED: begin
        if (is_quote) begin
          pmode = PM_QSEEN;
          return 1'b0;
        end
        if (is_eol) begin
          pmode = PM_BEFORE;
          after_cr = (b == CH_CR);
          tok.line_end = 1'b1;
          tok.row_error = 1'b1;
        end else begin
          tok.out_byte = b;
          tok.content_valid = 1'b1;
        end
        return 1'b1;
      end
      PM_QSEEN: begin
        if (is_delim) begin
          pmode = PM_BEFORE;
          tok.field_end = 1'b1;
        end else if (is_quote) begin
          pmode = PM_QUOTED;
          tok.out_byte = quote_q;
          tok.content_valid = 1'b1;
        end else if (is_eol) begin
          pmode = PM_BEFORE;
          after_cr = (b == CH_CR);
          tok.field_end = 1'b1;
          tok.line_end = 1'b1;
        end else begin
          // stray byte after the closing quote
          pmode = PM_SKIP;
          tok.row_error = 1'b1;
        end
        return 1'b1;
      end
      PM_SKIP: begin
        if (!is_eol) return 1'b0;
        pmode = PM_BEFORE;
        after_cr = (b == CH_CR);
        tok.line_end = 1'b1;
        tok.row_error = 1'b1;
        return 1'b1;
      end
      default: begin
        if (is_delim) begin
          pmode = PM_BEFORE;
          tok.field_end = 1'b1;
        end else if (is_quote) begin
          pmode = PM_QUOTED;
          return 1'b0;
        end else if (is_eol) begin
          pmode = PM_BEFORE;
          after_cr = (b == CH_CR);
          tok.field_end = 1'b1;
          tok.line_end = 1'b1;
        end else begin
          pmode = PM_PLAIN;
          tok.out_byte = b;
          tok.content_valid = 1'b1;
        end
        return 1'b1;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Append one byte to the text still to be sent.
  function automatic void add_text(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  // Pick a random byte that has no special meaning in the given context.
  function automatic logic [7:0] pick_content(input bit in_quotes);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == quote_q || b == CH_CR || b == CH_LF || (!in_quotes && b == delim_q));
    return b;
  endfunction

  task automatic push_field(input bit broken);
    int style;
    int len;
    int pick;
    style = $urandom_range(0, 4);
    len = $urandom_range(0, 6);
    if (style == 0) return;
    if (style <= 2) begin
      repeat (len + 1) add_text(pick_content(1'b0));
      return;
    end
    add_text(quote_q);
    repeat (len) begin
      pick = $urandom_range(0, 5);
      if (pick == 0) begin
        add_text(quote_q);
        add_text(quote_q);
      end else if (pick == 1) begin
        add_text(delim_q);
      end else begin
        add_text(pick_content(1'b1));
      end
    end
    // a broken field either stays open to the line end or gets a stray byte
    if (broken && $urandom_range(0, 1) == 0) return;
    add_text(quote_q);
    if (broken) add_text(pick_content(1'b0));
  endtask

  task automatic push_row();
    int kind;
    int nf;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 12)) add_text(8'($urandom_range(0, 255)));
      return;
    end
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) add_text(delim_q);
      push_field(kind < 22 && $urandom_range(0, 1) == 1);
    end
    case ($urandom_range(0, 2))
      0: add_text(CH_CR);
      1: add_text(CH_LF);
      default: begin
        add_text(CH_CR);
        add_text(CH_LF);
      end
    endcase
  endtask

  task automatic write_cfg(input logic [csvt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] val);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == csvt_pkg::CFG_IDX_DELIM) delim_q = val;
    else quote_q = val;
  endtask

  // Hold the sender until every token is back and the pipeline has settled.
  task automatic wait_drained();
    while (text_q.size() != 0 || in_ch.valid || pending_tokens.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input transfers feed the model; output transfers are checked.
  always @(posedge clk) begin
    csvt_pkg::result_t tok;
    csvt_pkg::result_t want;
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    if (in_fire) begin
      void'(text_q.pop_front());
      if (tokenize_byte(in_ch.in_byte, tok)) pending_tokens.insert(pending_tokens.size(), tok);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_tokens.size() == 0) begin
        report_mismatch($sformatf("token %0d arrived with none expected", token_idx));
      end else begin
        want = pending_tokens.pop_front();
        if (out_ch.out_byte !== want.out_byte)
          report_mismatch($sformatf("token %0d out_byte %h, expected %h",
                                    token_idx, out_ch.out_byte, want.out_byte));
        if (out_ch.content_valid !== want.content_valid)
          report_mismatch($sformatf("token %0d content_valid %b, expected %b",
                                    token_idx, out_ch.content_valid, want.content_valid));
        if (out_ch.field_end !== want.field_end)
          report_mismatch($sformatf("token %0d field_end %b, expected %b",
                                    token_idx, out_ch.field_end, want.field_end));
        if (out_ch.line_end !== want.line_end)
          report_mismatch($sformatf("token %0d line_end %b, expected %b",
                                    token_idx, out_ch.line_end, want.line_end));
        if (out_ch.row_error !== want.row_error)
          report_mismatch($sformatf("token %0d row_error %b, expected %b",
                                    token_idx, out_ch.row_error, want.row_error));
      end
      token_idx++;
    end
  end

  // Sender: bursts of transfers separated by random gaps.
  always @(negedge clk) begin
    if (in_fire) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
    end
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left--;
      end else if (text_q.size() != 0) begin
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= text_q[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random 16-bit ready patterns, plus a long hold on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (hold_ack != hold_req) begin
      hold_ack = hold_req;
      hold_left = LONG_HOLD - 1;
      out_ch.ready <= 1'b0;
    end else begin
      if (stall_phase == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pat = 16'hFFFF;
          1: stall_pat = 16'($urandom_range(0, 16'hFFFF));
          2: stall_pat = 16'($urandom_range(0, 16'hFFFF) | $urandom_range(0, 16'hFFFF));
          default: stall_pat = 16'($urandom_range(0, 16'hFFFF) & $urandom_range(0, 16'hFFFF))
                               | 16'h0001;
        endcase
        stall_phase = 16;
      end
      stall_phase--;
      out_ch.ready <= stall_pat[stall_phase];
    end
  end

  initial begin
    logic [7:0] d;
    logic [7:0] q;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    out_ch.ready  = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = csvt_pkg::CFG_IDX_DELIM;
    cfg_wr_data   = 8'h00;
    rst_n         = 1'b0;
    delim_q       = CH_DELIM;
    quote_q       = CH_QUOTE;
    pmode         = PM_BEFORE;
    after_cr      = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: empty fields, doubled quote, delimiter inside quotes,
    // CRLF, stray byte after a closing quote with skip to line end, line end
    // inside quotes, quote inside a plain field, empty line, byte extremes.
    text_q = '{8'h61, CH_DELIM, CH_DELIM, CH_QUOTE, 8'h78, CH_QUOTE, CH_QUOTE,
               CH_DELIM, CH_QUOTE, CH_CR, CH_LF, CH_QUOTE, 8'h71, CH_QUOTE,
               8'h62, 8'hFF, CH_LF, CH_QUOTE, 8'h00, CH_CR, CH_LF, 8'hFF,
               CH_QUOTE, CH_LF, CH_LF};
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        1: begin d = 8'h00; q = 8'hFF; end
        2: begin d = 8'hFF; q = 8'h00; end
        3: begin d = 8'h09; q = 8'h27; end
        4: begin d = CH_CR; q = CH_LF; end
        5: begin d = CH_QUOTE; q = CH_QUOTE; end
        6: begin d = CH_LF; q = CH_CR; end
        7: begin d = 8'($urandom_range(0, 255)); q = 8'($urandom_range(0, 255)); end
        default: begin d = CH_DELIM; q = CH_QUOTE; end
      endcase
      write_cfg(csvt_pkg::CFG_IDX_DELIM, d);
      write_cfg(csvt_pkg::CFG_IDX_QUOTE, q);
      while (text_q.size() < ITEMS_PER_PHASE) push_row();
      // let the output back up while the sender keeps offering bytes
      if (ph == 2) hold_req++;
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
